FILE: rtl/console_bus_address_decoder_defines.svh
// Assertion macros used by the checker file of the bus address decoder.
`ifndef CONSOLE_BUS_ADDRESS_DECODER_DEFINES_SVH
`define CONSOLE_BUS_ADDRESS_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBAD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cbad_pkg.sv
// Types, constants and a helper function of the bus address decoder.
package cbad_pkg;

  localparam logic [15:0] VIDEO_BASE = 16'h2000;
  localparam logic [15:0] IO_BASE    = 16'h4000;
  localparam logic [15:0] DMA_ADDR   = 16'h4014;
  localparam logic [15:0] ROM_BASE   = 16'h8000;

  localparam int unsigned OFFSET_W = 19;
  localparam int unsigned CODE_W   = 4;

  // Access kinds.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Video register indexes; status, sprite data and video data carry read data.
  localparam logic [2:0] VREG_CTRL    = 3'd0;
  localparam logic [2:0] VREG_MASK    = 3'd1;
  localparam logic [2:0] VREG_STATUS  = 3'd2;
  localparam logic [2:0] VREG_OAMADDR = 3'd3;
  localparam logic [2:0] VREG_OAMDATA = 3'd4;
  localparam logic [2:0] VREG_SCROLL  = 3'd5;
  localparam logic [2:0] VREG_ADDR    = 3'd6;
  localparam logic [2:0] VREG_DATA    = 3'd7;

  // Codes reported for register writes.
  localparam logic [CODE_W-1:0] WR_NONE    = 4'd0;
  localparam logic [CODE_W-1:0] WR_CTRL    = 4'd1;
  localparam logic [CODE_W-1:0] WR_MASK    = 4'd2;
  localparam logic [CODE_W-1:0] WR_OAMADDR = 4'd3;
  localparam logic [CODE_W-1:0] WR_OAMDATA = 4'd4;
  localparam logic [CODE_W-1:0] WR_SCROLL  = 4'd5;
  localparam logic [CODE_W-1:0] WR_ADDR    = 4'd6;
  localparam logic [CODE_W-1:0] WR_DATA    = 4'd7;
  localparam logic [CODE_W-1:0] WR_OAMDMA  = 4'd8;

  // Configuration register indexes.
  localparam logic REG_PRG_BANK = 1'b0;

  typedef struct packed {
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  ppu_status;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          read_data;
    logic                rom_fetch;
    logic [OFFSET_W-1:0] rom_offset;
    logic [CODE_W-1:0]   ppu_reg_written;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_QUOT   = 5'b00100,
    ST_ACCESS = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  // Maps a video register index to the code reported when it is written.
  function automatic logic [CODE_W-1:0] video_write_code(input logic [2:0] idx);
    logic [CODE_W-1:0] code;
    unique case (idx)
      VREG_CTRL:    code = WR_CTRL;
      VREG_MASK:    code = WR_MASK;
      VREG_STATUS:  code = WR_NONE;
      VREG_OAMADDR: code = WR_OAMADDR;
      VREG_OAMDATA: code = WR_OAMDATA;
      VREG_SCROLL:  code = WR_SCROLL;
      VREG_ADDR:    code = WR_ADDR;
      default:      code = WR_DATA;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/console_bus_address_decoder.sv
// Top level of the console processor bus address decoder.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+------------------------------
//   input   | start / busy           | in_item (cbad_pkg::in_item_t)
//   result  | out_valid strobe       | out_item (cbad_pkg::out_item_t)
//   config  | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// After an access is accepted it passes through ST_QUOT, which splits the
// address with a reciprocal multiplication, ST_ACCESS, for the work RAM
// access, and ST_RESP, in which the RAM's registered read data is shown with
// the strobe. busy falls as the strobe ends, so the block takes no new transfer
// before the last one's result has been shown; the mirror split and the RAM's
// registered read are why these states are needed.
// After reset the block sweeps the work RAM to zero, one byte a cycle, and busy
// stays high until the last byte is cleared; configuration writes are taken
// throughout. The result is shown for exactly one cycle and cannot be stalled.
module console_bus_address_decoder #(
  parameter int unsigned RAM_BYTES      = 2048,
  parameter int unsigned PRG_BANK_BYTES = 16384
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cbad_pkg::in_item_t  in_item,
  output logic                out_valid,
  output cbad_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IDX_W = $clog2(RAM_BYTES);
  // The RAM region spans 8 KiB, so the mirror index comes from 13 address bits.
  localparam int unsigned LOW_W = 13;
  localparam int unsigned SHIFT = 2 * LOW_W;
  // Rounded-up reciprocal; with both operands below 2**13 the quotient is exact.
  localparam int unsigned RECIP = ((1 << SHIFT) + RAM_BYTES - 1) / RAM_BYTES;
  localparam int unsigned Q_W   = $clog2((1 << LOW_W) / RAM_BYTES) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RAM_BYTES - 1);

  cbad_pkg::state_t   state_r, state_nxt;
  cbad_pkg::in_item_t req_r, req_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [Q_W-1:0]     quot_r, quot_nxt;
  logic [7:0]         sprite_data_r, sprite_data_nxt;
  logic [7:0]         video_data_r, video_data_nxt;

  logic [3:0]         prg_bank;
  logic [31:0]        recip_prod;
  logic [LOW_W:0]     quot_scaled;
  logic [LOW_W-1:0]   ram_rem;
  logic [IDX_W-1:0]   ram_addr;
  logic               ram_we;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  logic               in_ram, in_video, in_rom, is_dma;
  logic               is_write;
  logic [2:0]         vreg;

  cbad_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .prg_bank (prg_bank)
  );

  cbad_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_work_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Region decode of the latched access.
  assign is_write = (req_r.req_type == cbad_pkg::REQ_WRITE);
  assign in_ram   = (req_r.address < cbad_pkg::VIDEO_BASE);
  assign in_video = !in_ram && (req_r.address < cbad_pkg::IO_BASE);
  assign in_rom   = (req_r.address >= cbad_pkg::ROM_BASE);
  assign is_dma   = (req_r.address == cbad_pkg::DMA_ADDR);
  assign vreg     = req_r.address[2:0];

  // Mirror index: address minus quotient times RAM size.
  assign recip_prod  = 32'(req_r.address[LOW_W-1:0]) * 32'(RECIP);
  assign quot_scaled = (LOW_W+1)'(quot_r) * (LOW_W+1)'(RAM_BYTES);
  assign ram_rem     = LOW_W'(req_r.address[LOW_W-1:0] - quot_scaled[LOW_W-1:0]);

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    clr_cnt_nxt     = clr_cnt_r;
    quot_nxt        = quot_r;
    sprite_data_nxt = sprite_data_r;
    video_data_nxt  = video_data_r;
    ram_addr        = IDX_W'(ram_rem);
    ram_we          = 1'b0;
    ram_wdata       = req_r.write_data;

    unique case (state_r)
      cbad_pkg::ST_CLEAR: begin
        ram_addr    = clr_cnt_r;
        ram_we      = 1'b1;
        ram_wdata   = 8'd0;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = cbad_pkg::ST_IDLE;
        end
      end
      cbad_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          state_nxt = cbad_pkg::ST_QUOT;
        end
      end
      cbad_pkg::ST_QUOT: begin
        quot_nxt  = Q_W'(recip_prod >> SHIFT);
        state_nxt = cbad_pkg::ST_ACCESS;
      end
      cbad_pkg::ST_ACCESS: begin
        // Stores to RAM and to the two data registers happen here; a read
        // of the RAM returns its byte in the next cycle.
        ram_we = in_ram && is_write;
        if (in_video && is_write) begin
          if (vreg == cbad_pkg::VREG_OAMDATA) begin
            sprite_data_nxt = req_r.write_data;
          end else if (vreg == cbad_pkg::VREG_DATA) begin
            video_data_nxt = req_r.write_data;
          end
        end
        state_nxt = cbad_pkg::ST_RESP;
      end
      cbad_pkg::ST_RESP: begin
        state_nxt = cbad_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cbad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= cbad_pkg::ST_CLEAR;
      clr_cnt_r     <= '0;
      sprite_data_r <= 8'd0;
      video_data_r  <= 8'd0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      sprite_data_r <= sprite_data_nxt;
      video_data_r  <= video_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    quot_r <= quot_nxt;
  end

  assign busy      = (state_r != cbad_pkg::ST_IDLE);
  assign out_valid = (state_r == cbad_pkg::ST_RESP);

  // Result fields, formed from the latched access during the strobe cycle.
  always_comb begin
    out_item.read_data       = 8'd0;
    out_item.rom_fetch       = 1'b0;
    out_item.rom_offset      = '0;
    out_item.ppu_reg_written = cbad_pkg::WR_NONE;
    if (is_write) begin
      if (in_video) begin
        out_item.ppu_reg_written = cbad_pkg::video_write_code(vreg);
      end else if (is_dma) begin
        out_item.ppu_reg_written = cbad_pkg::WR_OAMDMA;
      end
    end else if (in_ram) begin
      out_item.read_data = ram_rdata;
    end else if (in_video) begin
      if (vreg == cbad_pkg::VREG_STATUS) begin
        out_item.read_data = req_r.ppu_status;
      end else if (vreg == cbad_pkg::VREG_OAMDATA) begin
        out_item.read_data = sprite_data_r;
      end else if (vreg == cbad_pkg::VREG_DATA) begin
        out_item.read_data = video_data_r;
      end
    end else if (in_rom) begin
      out_item.rom_fetch  = 1'b1;
      out_item.rom_offset = cbad_pkg::OFFSET_W'(
          cbad_pkg::OFFSET_W'(prg_bank) * cbad_pkg::OFFSET_W'(PRG_BANK_BYTES)
          + cbad_pkg::OFFSET_W'(req_r.address[14:0]));
    end
  end

endmodule

FILE: rtl/cbad_ram.sv
// Generic single-port synchronous RAM with a registered read.
module cbad_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/cbad_cfg.sv
// APB-style configuration register block holding the program ROM bank.
module cbad_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  prg_bank
);

  logic [3:0] prg_bank_r;
  logic [3:0] prg_bank_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    prg_bank_nxt = prg_bank_r;
    if (wr_en && (paddr[2] == cbad_pkg::REG_PRG_BANK)) begin
      prg_bank_nxt = pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r <= '0;
    end else begin
      prg_bank_r <= prg_bank_nxt;
    end
  end

  // Only the bank register is readable; the unused slot reads as zero.
  assign prdata   = (paddr[2] == cbad_pkg::REG_PRG_BANK) ? {28'd0, prg_bank_r} : 32'd0;
  assign prg_bank = prg_bank_r;

endmodule

FILE: rtl/cbad_checker.sv
// Port-level checker for the bus address decoder, bound to the top level.
`include "console_bus_address_decoder_defines.svh"

module cbad_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input cbad_pkg::out_item_t out_item
);

  logic rom_res;
  logic rest_zero;
  logic plain_res;
  logic off_zero;

  assign rom_res   = out_valid && out_item.rom_fetch;
  assign rest_zero = (out_item.read_data == 8'd0)
                     && (out_item.ppu_reg_written == cbad_pkg::WR_NONE);
  assign plain_res = out_valid && !out_item.rom_fetch;
  assign off_zero  = (out_item.rom_offset == '0);

  `CBAD_ASSERT_SAME(a_result_while_busy, clk, rst_n, out_valid, busy, "result outside a transfer")
  `CBAD_ASSERT_NEXT(a_accept_sets_busy, clk, rst_n, start && !busy, busy, "accept did not set busy")
  `CBAD_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held")
  `CBAD_ASSERT_SAME(a_rom_fields, clk, rst_n, rom_res, rest_zero, "ROM fetch with stray fields")
  `CBAD_ASSERT_SAME(a_offset_zero, clk, rst_n, plain_res, off_zero, "offset without ROM fetch")

endmodule

bind console_bus_address_decoder cbad_checker u_cbad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
